/* rtl/core/dadf_pkg.sv */
// ----------------------------------------------------------------------------
// dadf_pkg
// Shared types and constants for the anchor decode and filter block.
// ----------------------------------------------------------------------------
package dadf_pkg;

  localparam int unsigned DEF_ANCHORS = 8400;
  localparam int unsigned DEF_CLASSES = 80;
  localparam int unsigned DEF_LANES   = 4;

  // Classes that have an enable bit in the mask registers
  localparam int unsigned MAX_CLASSES = 80;
  // Score fields carried by one request
  localparam int unsigned SCORE_FIELDS = 4;

  localparam int unsigned SCORE_W  = 16;
  localparam int unsigned CLASS_W  = 7;
  localparam int unsigned ANCHOR_W = 14;
  localparam int unsigned COORD_W  = 16;
  localparam int unsigned PAD_W    = 10;
  localparam int unsigned INV_W    = 20;
  localparam int unsigned GROUP_W  = 5;
  // Lane class number before range check: group * lanes + lane, lanes <= 8
  localparam int unsigned LCLASS_W = 8;

  localparam int unsigned APB_DATA_W = 64;
  localparam int unsigned APB_ADDR_W = 6;
  localparam int unsigned REG_IDX_W  = 3;

  // Corner arithmetic widths
  localparam int unsigned OFF_W  = 19;  // signed Q.7 offset
  localparam int unsigned PROD_W = 40;  // signed Q.19 product
  localparam int unsigned FRAC_SHIFT = 19;

  localparam logic [SCORE_W-1:0]     RST_CONF_THRESHOLD = 16'h4000;
  localparam logic [63:0]            RST_CLASS_MASK_LOW = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [15:0]            RST_CLASS_MASK_HIGH = 16'hFFFF;
  localparam logic [PAD_W-1:0]       RST_PAD = '0;
  localparam logic [INV_W-1:0]       RST_INV_SCALE = 20'd4096;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_CONF_THRESHOLD  = 3'd0,
    REG_CLASS_MASK_LOW  = 3'd1,
    REG_CLASS_MASK_HIGH = 3'd2,
    REG_PAD_X           = 3'd3,
    REG_PAD_Y           = 3'd4,
    REG_INV_SCALE       = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [15:0]        center_x;
    logic [15:0]        center_y;
    logic [15:0]        box_width;
    logic [15:0]        box_height;
    logic [GROUP_W-1:0] group_index;
    logic [15:0]        score_lane0;
    logic [15:0]        score_lane1;
    logic [15:0]        score_lane2;
    logic [15:0]        score_lane3;
    logic               last_group;
  } in_item_t;

  typedef struct packed {
    logic [ANCHOR_W-1:0]       anchor_number;
    logic [CLASS_W-1:0]        class_id;
    logic [SCORE_W-1:0]        best_score_out;
    logic signed [COORD_W-1:0] left_x;
    logic signed [COORD_W-1:0] top_y;
    logic signed [COORD_W-1:0] right_x;
    logic signed [COORD_W-1:0] bottom_y;
  } out_item_t;

  // What one lane found for the current request
  typedef struct packed {
    logic               hit;
    logic [SCORE_W-1:0] score;
    logic [CLASS_W-1:0] class_id;
  } lane_cand_t;

  // Running arg-max of the anchor including the current request
  typedef struct packed {
    logic               found;
    logic [SCORE_W-1:0] best;
    logic [CLASS_W-1:0] class_id;
  } anchor_sum_t;

  // Load enables of the corner pipeline
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } stage_en_t;

  // Result fields that ride alongside the corner pipeline
  typedef struct packed {
    logic [ANCHOR_W-1:0] anchor_number;
    logic [CLASS_W-1:0]  class_id;
    logic [SCORE_W-1:0]  best_score;
  } result_meta_t;

endpackage

/* rtl/core/dadf_lane.sv */
// ----------------------------------------------------------------------------
// dadf_lane
// One score lane: class number, enable check and compare to running best.
// ----------------------------------------------------------------------------
module dadf_lane #(
  parameter int unsigned CLASSES = dadf_pkg::DEF_CLASSES,
  parameter int unsigned LANES   = dadf_pkg::DEF_LANES,
  parameter int unsigned LANE_ID = 0
) (
  input  logic [dadf_pkg::GROUP_W-1:0]     group_index_i,
  input  logic [dadf_pkg::SCORE_W-1:0]     score_i,
  input  logic [dadf_pkg::MAX_CLASSES-1:0] class_mask_i,
  input  logic [dadf_pkg::SCORE_W-1:0]     running_best_i,
  output dadf_pkg::lane_cand_t             cand_o
);
  import dadf_pkg::*;

  logic [LCLASS_W-1:0] lane_class;
  logic                class_en;

  assign lane_class = LCLASS_W'(32'(group_index_i) * LANES + LANE_ID);

  // Classes past the configured count, or past the mask, are ignored
  assign class_en = (lane_class < LCLASS_W'(CLASSES)) &&
                    (lane_class < LCLASS_W'(MAX_CLASSES)) &&
                    class_mask_i[lane_class[CLASS_W-1:0]];

  assign cand_o.hit      = class_en && (score_i > running_best_i);
  assign cand_o.score    = score_i;
  assign cand_o.class_id = lane_class[CLASS_W-1:0];

endmodule

/* rtl/core/dadf_merge.sv */
// ----------------------------------------------------------------------------
// dadf_merge
// Combines the lane candidates into the running arg-max of one anchor.
// ----------------------------------------------------------------------------
module dadf_merge #(
  parameter int unsigned NUM_LANES = dadf_pkg::SCORE_FIELDS
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    accept_i,
  input  logic                    last_group_i,
  input  dadf_pkg::lane_cand_t    cand_i [NUM_LANES],
  output logic [dadf_pkg::SCORE_W-1:0] running_best_o,
  output dadf_pkg::anchor_sum_t   sum_o
);
  import dadf_pkg::*;

  anchor_sum_t run_q, run_d;
  logic               pick_v;
  logic [SCORE_W-1:0] pick_s;
  logic [CLASS_W-1:0] pick_c;

  // Every hit already beats the running best; among hits the first maximum wins
  always_comb begin
    pick_v = 1'b0;
    pick_s = '0;
    pick_c = '0;
    for (int unsigned i = 0; i < NUM_LANES; i++) begin
      if (cand_i[i].hit && (!pick_v || (cand_i[i].score > pick_s))) begin
        pick_v = 1'b1;
        pick_s = cand_i[i].score;
        pick_c = cand_i[i].class_id;
      end
    end
  end

  always_comb begin
    sum_o.found    = run_q.found | pick_v;
    sum_o.best     = pick_v ? pick_s : run_q.best;
    sum_o.class_id = pick_v ? pick_c : run_q.class_id;
  end

  always_comb begin
    run_d = run_q;
    if (accept_i) begin
      // clear at the end of each anchor
      run_d = last_group_i ? '0 : sum_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= '0;
    end else begin
      run_q <= run_d;
    end
  end

  assign running_best_o = run_q.best;

endmodule

/* rtl/core/dadf_unbox.sv */
// ----------------------------------------------------------------------------
// dadf_unbox
// Corner pipeline: letterbox offset, scale multiply, truncate and saturate.
// ----------------------------------------------------------------------------
module dadf_unbox #(
  parameter bit ADD_EXTENT = 1'b0
) (
  input  logic                           clk_i,
  input  dadf_pkg::stage_en_t            en_i,
  input  logic [15:0]                    center_i,
  input  logic [15:0]                    extent_i,
  input  logic [dadf_pkg::PAD_W-1:0]     pad_i,
  input  logic [dadf_pkg::INV_W-1:0]     inv_scale_i,
  output logic signed [dadf_pkg::COORD_W-1:0] corner_o
);
  import dadf_pkg::*;

  logic signed [OFF_W-1:0]   off_d, off_q;
  logic signed [OFF_W-1:0]   c2, ext, padq;
  logic signed [PROD_W-1:0]  prod_d, prod_q;
  logic [PROD_W-1:0]         mag;
  logic [PROD_W-FRAC_SHIFT-1:0] whole;
  logic                      neg;
  logic signed [COORD_W-1:0] corner_d, corner_q;

  // Offset in Q.7: 2*center -/+ extent - 128*pad
  assign c2   = $signed({2'b00, center_i, 1'b0});
  assign ext  = $signed({3'b000, extent_i});
  assign padq = $signed({2'b00, pad_i, 7'b0000000});
  assign off_d = ADD_EXTENT ? (c2 + ext - padq) : (c2 - ext - padq);

  assign prod_d = PROD_W'(off_q * $signed({1'b0, inv_scale_i}));

  // Truncate toward zero on the magnitude, then saturate
  always_comb begin
    neg   = prod_q[PROD_W-1];
    mag   = neg ? $unsigned(-prod_q) : $unsigned(prod_q);
    whole = mag[PROD_W-1:FRAC_SHIFT];
    if (neg) begin
      if (whole > (PROD_W-FRAC_SHIFT)'(32768)) begin
        corner_d = 16'sh8000;
      end else begin
        corner_d = $signed(~whole[COORD_W-1:0] + 16'd1);
      end
    end else begin
      if (whole > (PROD_W-FRAC_SHIFT)'(32767)) begin
        corner_d = 16'sh7FFF;
      end else begin
        corner_d = $signed(whole[COORD_W-1:0]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      off_q <= off_d;
    end
    if (en_i.s2) begin
      prod_q <= prod_d;
    end
    if (en_i.s3) begin
      corner_q <= corner_d;
    end
  end

  assign corner_o = corner_q;

endmodule

/* rtl/core/detector_anchor_decode_filter.sv */
// ----------------------------------------------------------------------------
// detector_anchor_decode_filter
// Per-anchor class arg-max, confidence filter and letterbox box decode.
// ----------------------------------------------------------------------------
// Takes one score group per cycle with no stall of its own: up to four score lanes
// compare against the anchor's running best in parallel and a merge step folds
// the winners in, so the running arg-max is ready for the next group in the
// following cycle. On the last group of an anchor the survivor enters a
// three-stage corner pipeline (offset, scale multiply, truncate and saturate);
// a result passes the offset, product and corner registers to the output.
// The input stalls only when all three stages hold a result and the output is
// not taken.
module detector_anchor_decode_filter #(
  parameter int unsigned ANCHORS = dadf_pkg::DEF_ANCHORS,
  parameter int unsigned CLASSES = dadf_pkg::DEF_CLASSES,
  parameter int unsigned LANES   = dadf_pkg::DEF_LANES
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  dadf_pkg::in_item_t                 in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output dadf_pkg::out_item_t                out_data_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [dadf_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [dadf_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [dadf_pkg::APB_DATA_W-1:0]    prdata,
  output logic                               pready
);
  import dadf_pkg::*;

  localparam int unsigned NUM_LANES = (LANES < SCORE_FIELDS) ? LANES : SCORE_FIELDS;
  localparam logic [ANCHOR_W:0] ANCHOR_LIMIT = (ANCHOR_W+1)'(ANCHORS);

  // Configuration registers
  logic [SCORE_W-1:0] min_score_q;
  logic [63:0]        class_mask_low_q;
  logic [15:0]        class_mask_high_q;
  logic [PAD_W-1:0]   pad_x_q, pad_y_q;
  logic [INV_W-1:0]   inv_scale_q;
  logic               cfg_write;
  cfg_reg_e           cfg_idx;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;
  assign cfg_idx   = cfg_reg_e'(paddr[APB_ADDR_W-1:APB_ADDR_W-REG_IDX_W]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_score_q       <= RST_CONF_THRESHOLD;
      class_mask_low_q  <= RST_CLASS_MASK_LOW;
      class_mask_high_q <= RST_CLASS_MASK_HIGH;
      pad_x_q           <= RST_PAD;
      pad_y_q           <= RST_PAD;
      inv_scale_q       <= RST_INV_SCALE;
    end else if (cfg_write) begin
      unique case (cfg_idx)
        REG_CONF_THRESHOLD:  min_score_q       <= pwdata[SCORE_W-1:0];
        REG_CLASS_MASK_LOW:  class_mask_low_q  <= pwdata[63:0];
        REG_CLASS_MASK_HIGH: class_mask_high_q <= pwdata[15:0];
        REG_PAD_X:           pad_x_q           <= pwdata[PAD_W-1:0];
        REG_PAD_Y:           pad_y_q           <= pwdata[PAD_W-1:0];
        REG_INV_SCALE:       inv_scale_q       <= pwdata[INV_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_CONF_THRESHOLD:  prdata = APB_DATA_W'(min_score_q);
      REG_CLASS_MASK_LOW:  prdata = APB_DATA_W'(class_mask_low_q);
      REG_CLASS_MASK_HIGH: prdata = APB_DATA_W'(class_mask_high_q);
      REG_PAD_X:           prdata = APB_DATA_W'(pad_x_q);
      REG_PAD_Y:           prdata = APB_DATA_W'(pad_y_q);
      REG_INV_SCALE:       prdata = APB_DATA_W'(inv_scale_q);
      default:             prdata = '0;
    endcase
  end

  // Pipeline handshake
  logic s1_v_q, s1_v_d, s2_v_q, s2_v_d, out_v_q, out_v_d;
  logic s1_ready, s2_ready, s3_ready;
  logic accept, push;
  stage_en_t en;

  assign s3_ready   = !out_v_q || out_ready_i;
  assign s2_ready   = !s2_v_q || s3_ready;
  assign s1_ready   = !s1_v_q || s2_ready;
  assign in_ready_o = s1_ready;
  assign accept     = in_valid_i && in_ready_o;
  assign en         = '{s1: s1_ready, s2: s2_ready, s3: s3_ready};

  // Score lanes and merge
  logic [SCORE_W-1:0]     lane_score [SCORE_FIELDS];
  logic [MAX_CLASSES-1:0] class_mask;
  logic [SCORE_W-1:0]     running_best;
  lane_cand_t             cand [NUM_LANES];
  anchor_sum_t            sum;

  assign lane_score[0] = in_data_i.score_lane0;
  assign lane_score[1] = in_data_i.score_lane1;
  assign lane_score[2] = in_data_i.score_lane2;
  assign lane_score[3] = in_data_i.score_lane3;
  assign class_mask    = {class_mask_high_q, class_mask_low_q};

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    dadf_lane #(
      .CLASSES (CLASSES),
      .LANES   (LANES),
      .LANE_ID (l)
    ) u_lane (
      .group_index_i  (in_data_i.group_index),
      .score_i        (lane_score[l]),
      .class_mask_i   (class_mask),
      .running_best_i (running_best),
      .cand_o         (cand[l])
    );
  end

  dadf_merge #(
    .NUM_LANES (NUM_LANES)
  ) u_merge (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .last_group_i   (in_data_i.last_group),
    .cand_i         (cand),
    .running_best_o (running_best),
    .sum_o          (sum)
  );

  // Anchor counter
  logic [ANCHOR_W-1:0] anchor_q, anchor_d;
  logic [ANCHOR_W:0]   anchor_inc;

  assign anchor_inc = {1'b0, anchor_q} + 1'b1;

  always_comb begin
    anchor_d = anchor_q;
    if (accept && in_data_i.last_group) begin
      anchor_d = (anchor_inc >= ANCHOR_LIMIT) ? '0 : anchor_inc[ANCHOR_W-1:0];
    end
  end

  assign push = accept && in_data_i.last_group && sum.found &&
                (sum.best >= min_score_q);

  always_comb begin
    s1_v_d  = s1_ready ? push : s1_v_q;
    s2_v_d  = s2_ready ? s1_v_q : s2_v_q;
    out_v_d = s3_ready ? s2_v_q : out_v_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      anchor_q <= '0;
      s1_v_q   <= 1'b0;
      s2_v_q   <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      anchor_q <= anchor_d;
      s1_v_q   <= s1_v_d;
      s2_v_q   <= s2_v_d;
      out_v_q  <= out_v_d;
    end
  end

  // Result fields that travel beside the corners
  result_meta_t s1_meta_q, s2_meta_q, out_meta_q;

  always_ff @(posedge clk_i) begin
    if (en.s1) begin
      s1_meta_q <= '{anchor_number: anchor_q, class_id: sum.class_id,
                     best_score: sum.best};
    end
    if (en.s2) begin
      s2_meta_q <= s1_meta_q;
    end
    if (en.s3) begin
      out_meta_q <= s2_meta_q;
    end
  end

  logic signed [COORD_W-1:0] left_x, top_y, right_x, bottom_y;

  dadf_unbox #(.ADD_EXTENT(1'b0)) u_left (
    .clk_i       (clk_i),
    .en_i        (en),
    .center_i    (in_data_i.center_x),
    .extent_i    (in_data_i.box_width),
    .pad_i       (pad_x_q),
    .inv_scale_i (inv_scale_q),
    .corner_o    (left_x)
  );

  dadf_unbox #(.ADD_EXTENT(1'b0)) u_top (
    .clk_i       (clk_i),
    .en_i        (en),
    .center_i    (in_data_i.center_y),
    .extent_i    (in_data_i.box_height),
    .pad_i       (pad_y_q),
    .inv_scale_i (inv_scale_q),
    .corner_o    (top_y)
  );

  dadf_unbox #(.ADD_EXTENT(1'b1)) u_right (
    .clk_i       (clk_i),
    .en_i        (en),
    .center_i    (in_data_i.center_x),
    .extent_i    (in_data_i.box_width),
    .pad_i       (pad_x_q),
    .inv_scale_i (inv_scale_q),
    .corner_o    (right_x)
  );

  dadf_unbox #(.ADD_EXTENT(1'b1)) u_bottom (
    .clk_i       (clk_i),
    .en_i        (en),
    .center_i    (in_data_i.center_y),
    .extent_i    (in_data_i.box_height),
    .pad_i       (pad_y_q),
    .inv_scale_i (inv_scale_q),
    .corner_o    (bottom_y)
  );

  assign out_valid_o = out_v_q;

  always_comb begin
    out_data_o.anchor_number  = out_meta_q.anchor_number;
    out_data_o.class_id       = out_meta_q.class_id;
    out_data_o.best_score_out = out_meta_q.best_score;
    out_data_o.left_x         = left_x;
    out_data_o.top_y          = top_y;
    out_data_o.right_x        = right_x;
    out_data_o.bottom_y       = bottom_y;
  end

endmodule
